// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("%m: same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: next-cycle implication failed");

`endif

// ----- rtl/wsfe_pkg.sv -----
`timescale 1ns / 1ps

package wsfe_pkg;

   localparam int LED_COUNT        = 64;
   localparam int LEAD_RESET_SLOTS = 48;
   localparam int BITS_PER_LED     = 24;
   localparam int TRAIL_SLOTS      = 24;

   localparam int COLOUR_W = BITS_PER_LED;
   localparam int DUTY_W   = 16;
   localparam int INDEX_W  = 6;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 1;

   // Address width of the colour store.
   localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   // Slot counter covers the longest of the lead, data and trail runs.
   localparam int SLOT_MAX_A = (LEAD_RESET_SLOTS > TRAIL_SLOTS) ? LEAD_RESET_SLOTS : TRAIL_SLOTS;
   localparam int SLOT_MAX   = (SLOT_MAX_A > BITS_PER_LED) ? SLOT_MAX_A : BITS_PER_LED;
   localparam int SLOT_W     = $clog2(SLOT_MAX);

   // The shared step unit must hold either counter plus one, and every limit.
   localparam int STEP_W = ((SLOT_W > LED_W) ? SLOT_W : LED_W) + 1;

   // Bit position of the first bit sent for an LED (green MSB).
   localparam logic [4:0] MSB_POS = 5'(BITS_PER_LED - 1);

   // Request tdata layout, lowest bits first.
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_BUSY_BIT = DUTY_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET_ONE = 2'd0,
      KIND_SET_ALL = 2'd1,
      KIND_START   = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ONE_DUTY  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_DUTY = 1'b1;

   localparam logic [DUTY_W-1:0] ONE_DUTY_RESET  = 16'd58;
   localparam logic [DUTY_W-1:0] ZERO_DUTY_RESET = 16'd29;

endpackage

// ----- rtl/wsfe_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module wsfe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ws2812_strip_frame_encoder.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata: led_index, red, green, blue; tuser: kind
// rsp_      out  rsp_tvalid/rsp_tready  tdata: duty, busy_res; tuser: slot_is_data;
//                                       tlast: frame_end
// csr_      in   csr_we                 csr_index selects one_duty or zero_duty
//
// Set one, set all and start transactions complete in the cycle they are accepted.
// A tick passes through the store read (ST_READ) and result forming (ST_FORM) before its result
// is valid; req_tready stays low until the result is taken and the state machine is back in
// ST_IDLE. On the last bit of an LED a tick also passes through ST_LED, where the shared step
// unit steps the LED counter. A stall on rsp_ holds the result and keeps req_tready low.
// The store reads as all zero after reset through per-entry valid bits, with no clearing pass.

module ws2812_strip_frame_encoder (
   input  logic                                  clock,
   input  logic                                  reset,
   // led_index[5:0], red[13:6], green[21:14], blue[29:22], zero fill above.
   input  logic [wsfe_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // kind[1:0].
   input  logic [wsfe_pkg::KIND_W-1:0]           req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // duty[15:0], busy_res[16], zero fill above.
   output logic [wsfe_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // slot_is_data[0].
   output logic [0:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic [wsfe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wsfe_pkg::DUTY_W-1:0]           csr_wdata
);

   localparam int LED_W  = wsfe_pkg::LED_W;
   localparam int SLOT_W = wsfe_pkg::SLOT_W;
   localparam int STEP_W = wsfe_pkg::STEP_W;
   localparam int LEDS   = wsfe_pkg::LED_COUNT;

   // ST_READ issues the store read and computes the slot step, ST_FORM builds the result
   // and updates the slot counter, ST_LED steps the LED counter and ST_OUT waits for the sink.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FORM,
      ST_LED,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEAD,
      PH_DATA,
      PH_TRAIL
   } phase_type;

   state_type                        state_ff, state_in;
   phase_type                        phase_ff, phase_in;
   logic [SLOT_W-1:0]                slot_ff, slot_in;
   logic [LED_W-1:0]                 led_ff, led_in;
   logic [LEDS-1:0]                  valid_ff, valid_in;
   logic [wsfe_pkg::COLOUR_W-1:0]    fill_ff, fill_in;
   logic [wsfe_pkg::DUTY_W-1:0]      one_duty_ff, one_duty_in;
   logic [wsfe_pkg::DUTY_W-1:0]      zero_duty_ff, zero_duty_in;
   logic                             vsel_ff, vsel_in;
   logic [STEP_W-1:0]                step_sum_ff, step_sum_in;
   logic                             step_hit_ff, step_hit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [wsfe_pkg::DUTY_W-1:0]      rsp_duty_ff, rsp_duty_in;
   logic                             rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_busy_ff, rsp_busy_in;

   // Request fields.
   wsfe_pkg::kind_type               req_kind;
   logic [wsfe_pkg::INDEX_W-1:0]     req_led_index;
   logic [7:0]                       req_red;
   logic [7:0]                       req_green;
   logic [7:0]                       req_blue;
   logic [wsfe_pkg::COLOUR_W-1:0]    req_colour;
   logic                             req_accept;
   logic                             rsp_accept;

   // Store ports.
   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [wsfe_pkg::COLOUR_W-1:0]    ram_rd_data;
   logic [wsfe_pkg::COLOUR_W-1:0]    word;
   logic [4:0]                       bit_pos;

   // Shared step unit: one incrementer and one equality compare.
   logic [STEP_W-1:0]                unit_op;
   logic [STEP_W-1:0]                unit_limit;
   logic [STEP_W-1:0]                unit_sum;
   logic                             unit_hit;

   assign req_kind      = wsfe_pkg::kind_type'(req_tuser);
   assign req_led_index = req_tdata[5:0];
   assign req_red       = req_tdata[13:6];
   assign req_green     = req_tdata[21:14];
   assign req_blue      = req_tdata[29:22];
   // Store word layout: green in the top byte, then red, then blue.
   assign req_colour    = {req_green, req_red, req_blue};

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;

   assign ram_wr_en = req_accept && (req_kind == wsfe_pkg::KIND_SET_ONE) &&
                      (32'(req_led_index) < LEDS);
   assign ram_rd_en = (state_ff == ST_READ);

   wsfe_ram #(
      .WIDTH (wsfe_pkg::COLOUR_W),
      .DEPTH (LEDS)
   ) u_colour_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (LED_W'(req_led_index)),
      .wr_data (req_colour),
      .rd_en   (ram_rd_en),
      .rd_addr (led_ff),
      .rd_data (ram_rd_data)
   );

   // An entry that has not been written since reset or the last set all reads
   // as the fill colour.
   assign word    = vsel_ff ? ram_rd_data : fill_ff;
   assign bit_pos = wsfe_pkg::MSB_POS - slot_ff[4:0];

   always_comb begin
      if (state_ff == ST_LED) begin
         unit_op    = STEP_W'(led_ff);
         unit_limit = STEP_W'(LEDS);
      end else begin
         unit_op = STEP_W'(slot_ff);
         if (phase_ff == PH_LEAD) begin
            unit_limit = STEP_W'(wsfe_pkg::LEAD_RESET_SLOTS);
         end else if (phase_ff == PH_TRAIL) begin
            unit_limit = STEP_W'(wsfe_pkg::TRAIL_SLOTS);
         end else begin
            unit_limit = STEP_W'(wsfe_pkg::BITS_PER_LED);
         end
      end
      unit_sum = unit_op + STEP_W'(1);
      unit_hit = (unit_sum == unit_limit);
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      led_in       = led_ff;
      valid_in     = valid_ff;
      fill_in      = fill_ff;
      one_duty_in  = one_duty_ff;
      zero_duty_in = zero_duty_ff;
      vsel_in      = vsel_ff;
      step_sum_in  = step_sum_ff;
      step_hit_in  = step_hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_busy_in  = rsp_busy_ff;

      // Configuration writes are taken in any state.
      if (csr_we) begin
         unique case (csr_index)
            wsfe_pkg::CSR_ONE_DUTY:  one_duty_in  = csr_wdata;
            wsfe_pkg::CSR_ZERO_DUTY: zero_duty_in = csr_wdata;
         endcase
      end

      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_kind)
                  wsfe_pkg::KIND_SET_ONE: begin
                     if (32'(req_led_index) < LEDS) begin
                        valid_in[LED_W'(req_led_index)] = 1'b1;
                     end
                  end
                  wsfe_pkg::KIND_SET_ALL: begin
                     // Every entry now reads as this colour until written again.
                     fill_in  = req_colour;
                     valid_in = '0;
                  end
                  wsfe_pkg::KIND_START: begin
                     phase_in = PH_LEAD;
                     slot_in  = '0;
                     led_in   = '0;
                  end
                  wsfe_pkg::KIND_TICK: begin
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            vsel_in     = valid_ff[led_ff];
            step_sum_in = unit_sum;
            step_hit_in = unit_hit;
            state_in    = ST_FORM;
         end
         ST_FORM: begin
            rsp_valid_in = 1'b1;
            rsp_duty_in  = '0;
            rsp_data_in  = 1'b0;
            rsp_last_in  = 1'b0;
            rsp_busy_in  = (phase_ff != PH_IDLE);
            state_in     = ST_OUT;
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_LEAD: begin
                  if (step_hit_ff) begin
                     phase_in = PH_DATA;
                     slot_in  = '0;
                     led_in   = '0;
                  end else begin
                     slot_in = step_sum_ff[SLOT_W-1:0];
                  end
               end
               PH_DATA: begin
                  rsp_duty_in = word[bit_pos] ? one_duty_ff : zero_duty_ff;
                  rsp_data_in = 1'b1;
                  if (step_hit_ff) begin
                     // Last bit of this LED: move on to the next one.
                     slot_in  = '0;
                     state_in = ST_LED;
                  end else begin
                     slot_in = step_sum_ff[SLOT_W-1:0];
                  end
               end
               PH_TRAIL: begin
                  if (step_hit_ff) begin
                     rsp_last_in = 1'b1;
                     phase_in    = PH_IDLE;
                     slot_in     = '0;
                  end else begin
                     slot_in = step_sum_ff[SLOT_W-1:0];
                  end
               end
            endcase
         end
         ST_LED: begin
            if (unit_hit) begin
               led_in   = '0;
               phase_in = PH_TRAIL;
            end else begin
               led_in = unit_sum[LED_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_accept) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         slot_ff      <= '0;
         led_ff       <= '0;
         valid_ff     <= '0;
         fill_ff      <= '0;
         one_duty_ff  <= wsfe_pkg::ONE_DUTY_RESET;
         zero_duty_ff <= wsfe_pkg::ZERO_DUTY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         led_ff       <= led_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         one_duty_ff  <= one_duty_in;
         zero_duty_ff <= zero_duty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vsel_ff     <= vsel_in;
      step_sum_ff <= step_sum_in;
      step_hit_ff <= step_hit_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_busy_ff <= rsp_busy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(wsfe_pkg::RSP_TDATA_W - wsfe_pkg::DUTY_W - 1)'(0),
                        rsp_busy_ff, rsp_duty_ff};
   assign rsp_tuser  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/wsfe_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks for the strip frame encoder.
module wsfe_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tready,
   input logic [wsfe_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input logic [0:0]                            rsp_tuser,
   input logic                                  rsp_tlast,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready
);

   // The frame end slot still belongs to the frame.
   `ASSERT_IMPLIES(a_end_is_busy, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[wsfe_pkg::RSP_BUSY_BIT])

   // A data slot only occurs inside a frame.
   `ASSERT_IMPLIES(a_data_is_busy, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[wsfe_pkg::RSP_BUSY_BIT])

   // Reset, trailing and idle slots carry a zero compare value.
   `ASSERT_IMPLIES(a_low_slot_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[wsfe_pkg::DUTY_W-1:0] == '0)

   // No new transaction is taken while a result is still pending.
   `ASSERT_IMPLIES(a_no_accept_pending, clock, reset, rsp_tvalid, !req_tready)

   // A stalled result holds its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

endmodule

bind ws2812_strip_frame_encoder wsfe_checker u_wsfe_checker (.*);
